// ===== sv/grid_bfs_shortest_path_assert.svh =====
// assertion macros shared by the checker
`ifndef GRID_BFS_SHORTEST_PATH_ASSERT_SVH
`define GRID_BFS_SHORTEST_PATH_ASSERT_SVH
// implication checked every clock outside reset
`define GBFS_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");
// next-cycle implication
`define GBFS_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");
`endif

// ===== sv/gbfs_pkg.sv =====
// ------------------------------------------------------------------
// gbfs_pkg
// shared types and constants of the grid path searcher
// ------------------------------------------------------------------
package gbfs_pkg;
    localparam int MAX_ROWS_C = 16;
    localparam int MAX_COLS_C = 16;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_UNREACH = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] MARK_UNSEEN = 2'd0;
    localparam logic [1:0] MARK_QUEUED = 2'd1;
    localparam logic [1:0] MARK_DONE = 2'd2;

    localparam logic [0:0] CFG_ROWS = 1'b0;
    localparam logic [0:0] CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_SRC, S_CHECK, S_DEQ, S_QWAIT, S_NREQ, S_NTEST,
        S_BLACK, S_DSTREQ, S_DSTTEST, S_BACK, S_BACKW, S_STORE, S_READW, S_RESULT
    } state_t;

    typedef struct packed {
        logic load;      // latch the item
        logic clr_init;  // start mark clearing
        logic clr_step;
        logic src_enq;   // mark source queued, enqueue
        logic deq_req;
        logic deq_take;
        logic nb_req;    // read neighbour wall and mark
        logic nb_test;   // enqueue if free, advance direction
        logic mark_black;
        logic dst_req;
        logic back_init;
        logic back_step;
        logic back_store;
        logic res_fire;
        logic wall_wr;
        logic set_len;
    } ctrl_t;

    typedef struct packed {
        logic [1:0] op;
        logic clr_last;
        logic src_bad;     // source or destination out of grid, or source on a wall
        logic queue_empty;
        logic nb_last;     // last direction
        logic dst_black;
        logic dst_is_src;
        logic back_at_src;
        logic back_full;
        logic rd_ok;
    } stat_t;
endpackage

// ===== sv/gbfs_ram.sv =====
// ------------------------------------------------------------------
// gbfs_ram
// generic single write, single read RAM with registered read
// ------------------------------------------------------------------
module gbfs_ram #(
    parameter int WIDTH_P = 8,
    parameter int DEPTH_P = 256
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH_P)-1:0] waddr,
    input  logic [WIDTH_P-1:0]         wdata,
    input  logic [$clog2(DEPTH_P)-1:0] raddr,
    output logic [WIDTH_P-1:0]         rdata
);
    logic [WIDTH_P-1:0] mem [DEPTH_P];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/gbfs_ctrl.sv =====
// ------------------------------------------------------------------
// gbfs_ctrl
// sequencer of writes, searches and reads
// ------------------------------------------------------------------
module gbfs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  gbfs_pkg::stat_t st,
    output gbfs_pkg::ctrl_t ctl
);
    import gbfs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority case (st.op)
                    OP_SEARCH: state_next = S_CLEAR;
                    OP_READ: state_next = S_READW;
                    default: state_next = S_RESULT;
                endcase
            end
            S_CLEAR:
            begin
                if (st.clr_last)
                begin
                    state_next = S_SRC;
                end
            end
            S_SRC: state_next = st.src_bad ? S_RESULT : S_DEQ;
            S_DEQ: state_next = st.queue_empty ? S_DSTREQ : S_QWAIT;
            S_QWAIT: state_next = S_NREQ;
            S_NREQ: state_next = S_NTEST;
            S_NTEST: state_next = st.nb_last ? S_BLACK : S_NREQ;
            S_BLACK: state_next = S_DEQ;
            S_DSTREQ: state_next = S_DSTTEST;
            S_DSTTEST:
            begin
                if (!st.dst_black || st.dst_is_src)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_BACK;
                end
            end
            S_BACK: state_next = S_BACKW;
            S_BACKW: state_next = S_STORE;
            S_STORE:
            begin
                if (st.back_at_src || st.back_full)
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_BACK;
                end
            end
            S_READW: state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE: ctl.load = start;
            S_CHECK:
            begin
                ctl.clr_init = (st.op == OP_SEARCH);
                ctl.wall_wr = (st.op == OP_WRITE);
            end
            S_CLEAR: ctl.clr_step = 1'b1;
            S_SRC: ctl.src_enq = !st.src_bad;
            S_DEQ: ctl.deq_req = !st.queue_empty;
            S_QWAIT: ctl.deq_take = 1'b1;
            S_NREQ: ctl.nb_req = 1'b1;
            S_NTEST: ctl.nb_test = 1'b1;
            S_BLACK: ctl.mark_black = 1'b1;
            S_DSTREQ: ctl.dst_req = 1'b1;
            S_DSTTEST:
            begin
                ctl.back_init = 1'b1;
                ctl.set_len = st.dst_black && st.dst_is_src;
            end
            S_BACK: ;
            S_BACKW: ctl.back_step = 1'b1;
            S_STORE:
            begin
                ctl.back_store = 1'b1;
                ctl.set_len = st.back_at_src || st.back_full;
            end
            S_READW: ;
            S_RESULT: ctl.res_fire = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== sv/gbfs_datapath.sv =====
// ------------------------------------------------------------------
// gbfs_datapath
// maps, queue, path trace and result registers
// ------------------------------------------------------------------
module gbfs_datapath #(
    parameter int MAX_ROWS_P = gbfs_pkg::MAX_ROWS_C,
    parameter int MAX_COLS_P = gbfs_pkg::MAX_COLS_C
) (
    input  logic            clk,
    input  logic            rst_n,
    input  gbfs_pkg::ctrl_t ctl,
    output gbfs_pkg::stat_t st,
    input  logic            cfg_we,
    input  logic            cfg_sel,
    input  logic [4:0]      cfg_val,
    input  logic [1:0]      op,
    input  logic [3:0]      cell_row,
    input  logic [3:0]      cell_col,
    input  logic            wall_bit,
    input  logic [3:0]      dest_row,
    input  logic [3:0]      dest_col,
    input  logic [7:0]      path_index,
    output logic            result_valid,
    output logic [1:0]      status,
    output logic [7:0]      path_count,
    output logic [3:0]      path_row,
    output logic [3:0]      path_col
);
    import gbfs_pkg::*;

    localparam int RB = $clog2(MAX_ROWS_P);
    localparam int CB = $clog2(MAX_COLS_P);
    localparam int CELLS = MAX_ROWS_P * MAX_COLS_P;
    localparam int AB = $clog2(MAX_COLS_P) + $clog2(MAX_ROWS_P);
    localparam int ADEPTH = 1 << AB;
    localparam int NB = AB + 1;

    typedef struct packed {
        logic [RB-1:0] r;
        logic [CB-1:0] c;
    } cell_t;

    logic [4:0] rows_reg, cols_reg;
    logic [1:0] op_reg;
    logic [3:0] sr_reg, sc_reg, dr_reg, dc_reg, wr_row_reg, wr_col_reg;
    logic wall_val_reg;
    logic [7:0] pidx_reg;
    logic [NB-1:0] head_reg, tail_reg, clr_reg, n_reg, len_reg;
    cell_t cur_reg, nb_reg, bk_reg;
    logic [1:0] dir_reg;
    logic nb_ok_reg, src_bad_reg;
    logic [1:0] res_status_reg;
    logic res_valid_reg;

    logic [5:0] rows_eff, cols_eff;
    always_comb
    begin
        rows_eff = (rows_reg == 5'd0) ? 6'd1 : {1'b0, rows_reg};
        if (32'(rows_eff) > MAX_ROWS_P) rows_eff = 6'(MAX_ROWS_P);
        cols_eff = (cols_reg == 5'd0) ? 6'd1 : {1'b0, cols_reg};
        if (32'(cols_eff) > MAX_COLS_P) cols_eff = 6'(MAX_COLS_P);
    end

    function automatic logic [AB-1:0] addr_of(cell_t x);
        return AB'(x.r) * AB'(ADEPTH / (1 << RB)) + AB'(x.c);
    endfunction

    // ---------------- memories ----------------
    logic wall_we, wall_rd;
    logic [AB-1:0] wall_wa, wall_ra;
    logic [1:0] col_wd, col_rd, par_wd, par_rd;
    logic col_we, par_we, q_we, p_we;
    logic [AB-1:0] col_wa, col_ra, par_wa, par_ra, q_wa, q_ra, p_wa, p_ra;
    logic [AB-1:0] q_wd, q_rd, p_wd, p_rd;

    gbfs_ram #(.WIDTH_P(1), .DEPTH_P(ADEPTH)) u_wall (.clk, .we(wall_we),
        .waddr(wall_wa), .wdata(wall_val_reg), .raddr(wall_ra), .rdata(wall_rd));
    gbfs_ram #(.WIDTH_P(2), .DEPTH_P(ADEPTH)) u_color (.clk, .we(col_we),
        .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
    gbfs_ram #(.WIDTH_P(2), .DEPTH_P(ADEPTH)) u_parent (.clk, .we(par_we),
        .waddr(par_wa), .wdata(par_wd), .raddr(par_ra), .rdata(par_rd));
    gbfs_ram #(.WIDTH_P(AB), .DEPTH_P(ADEPTH)) u_queue (.clk, .we(q_we),
        .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));
    gbfs_ram #(.WIDTH_P(AB), .DEPTH_P(ADEPTH)) u_path (.clk, .we(p_we),
        .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

    cell_t src_c, dst_c, wr_c, q_cell, bk_prev, p_cell;
    assign src_c = '{r: RB'(sr_reg), c: CB'(sc_reg)};
    assign dst_c = '{r: RB'(dr_reg), c: CB'(dc_reg)};
    assign wr_c = '{r: RB'(wr_row_reg), c: CB'(wr_col_reg)};
    assign q_cell = cell_t'(q_rd[RB+CB-1:0]);
    assign p_cell = cell_t'(p_rd[RB+CB-1:0]);

    // neighbour of current cell in direction dir
    logic nb_ok;
    cell_t nb_c;
    always_comb
    begin
        nb_c = cur_reg;
        unique case (dir_reg)
            2'd0:
            begin
                nb_ok = (6'(cur_reg.r) + 6'd1 < rows_eff);
                nb_c.r = cur_reg.r + RB'(1);
            end
            2'd1:
            begin
                nb_ok = (cur_reg.r != '0);
                nb_c.r = cur_reg.r - RB'(1);
            end
            2'd2:
            begin
                nb_ok = (cur_reg.c != '0);
                nb_c.c = cur_reg.c - CB'(1);
            end
            default:
            begin
                nb_ok = (6'(cur_reg.c) + 6'd1 < cols_eff);
                nb_c.c = cur_reg.c + CB'(1);
            end
        endcase
    end

    // undo the move stored for the traced cell
    always_comb
    begin
        bk_prev = bk_reg;
        unique case (par_rd)
            2'd0: bk_prev.r = bk_reg.r - RB'(1);
            2'd1: bk_prev.r = bk_reg.r + RB'(1);
            2'd2: bk_prev.c = bk_reg.c + CB'(1);
            default: bk_prev.c = bk_reg.c - CB'(1);
        endcase
    end

    logic enq_nb;
    assign enq_nb = ctl.nb_test && nb_ok_reg && !wall_rd && col_rd == MARK_UNSEEN;

    always_comb
    begin
        wall_we = ctl.wall_wr && 32'(wr_row_reg) < MAX_ROWS_P && 32'(wr_col_reg) < MAX_COLS_P;
        wall_wa = addr_of(wr_c);
        // the source wall is probed during the clear sweep
        wall_ra = ctl.clr_step ? addr_of(src_c) : addr_of(nb_c);
        col_ra = addr_of(nb_c);
        col_we = 1'b0;
        col_wa = AB'(clr_reg);
        col_wd = MARK_UNSEEN;
        if (ctl.clr_step)
        begin
            col_we = 1'b1;
        end
        else if (ctl.src_enq)
        begin
            col_we = 1'b1;
            col_wa = addr_of(src_c);
            col_wd = MARK_QUEUED;
        end
        else if (enq_nb)
        begin
            col_we = 1'b1;
            col_wa = addr_of(nb_reg);
            col_wd = MARK_QUEUED;
        end
        else if (ctl.mark_black)
        begin
            col_we = 1'b1;
            col_wa = addr_of(cur_reg);
            col_wd = MARK_DONE;
        end
        if (ctl.dst_req)
        begin
            col_ra = addr_of(dst_c);
        end
        par_we = enq_nb;
        par_wa = addr_of(nb_reg);
        par_wd = dir_reg;
        par_ra = addr_of(bk_reg);
        q_we = ctl.src_enq || enq_nb;
        q_wa = AB'(tail_reg);
        q_wd = ctl.src_enq ? addr_of(src_c) : addr_of(nb_reg);
        q_ra = AB'(head_reg);
        p_we = ctl.back_store && !(bk_reg == src_c);
        p_wa = AB'(n_reg);
        p_wd = addr_of(bk_reg);
        // the trace stores from the destination side
        p_ra = AB'(32'(len_reg) - 32'(pidx_reg) - 32'd1);
    end

    assign st.op = op_reg;
    assign st.clr_last = (clr_reg == NB'(ADEPTH - 1));
    assign st.src_bad = src_bad_reg || wall_rd;
    assign st.queue_empty = (head_reg == tail_reg) || (32'(head_reg) >= CELLS);
    assign st.nb_last = (dir_reg == 2'd3);
    assign st.dst_black = (col_rd == MARK_DONE);
    assign st.dst_is_src = (src_c == dst_c);
    assign st.back_at_src = (bk_reg == src_c);
    assign st.back_full = (32'(n_reg) >= CELLS - 1);
    assign st.rd_ok = (32'(pidx_reg) < 32'(len_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 5'd16;
            cols_reg <= 5'd16;
            len_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_sel == CFG_ROWS) rows_reg <= cfg_val;
                else cols_reg <= cfg_val;
            end
            res_valid_reg <= ctl.res_fire;
            if (ctl.set_len)
            begin
                len_reg <= ctl.back_store ? n_reg : '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg <= op;
            sr_reg <= cell_row;
            sc_reg <= cell_col;
            dr_reg <= dest_row;
            dc_reg <= dest_col;
            wr_row_reg <= cell_row;
            wr_col_reg <= cell_col;
            wall_val_reg <= wall_bit;
            pidx_reg <= path_index;
            res_status_reg <= ST_DONE;
        end
        if (ctl.clr_init)
        begin
            clr_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            cur_reg <= src_c;
            dir_reg <= 2'd0;
            src_bad_reg <= 6'(sr_reg) >= rows_eff || 6'(sc_reg) >= cols_eff
                || 6'(dr_reg) >= rows_eff || 6'(dc_reg) >= cols_eff;
            res_status_reg <= ST_UNREACH;
        end
        if (ctl.clr_step)
        begin
            clr_reg <= clr_reg + NB'(1);
        end
        if (ctl.src_enq)
        begin
            tail_reg <= tail_reg + NB'(1);
        end
        if (ctl.deq_req)
        begin
            head_reg <= head_reg + NB'(1);
        end
        if (ctl.deq_take)
        begin
            cur_reg <= q_cell;
            dir_reg <= 2'd0;
        end
        if (ctl.nb_req)
        begin
            nb_reg <= nb_c;
            nb_ok_reg <= nb_ok;
        end
        if (ctl.nb_test)
        begin
            dir_reg <= dir_reg + 2'd1;
            if (enq_nb && 32'(tail_reg) < CELLS)
            begin
                tail_reg <= tail_reg + NB'(1);
            end
        end
        if (ctl.back_init)
        begin
            bk_reg <= dst_c;
            n_reg <= '0;
            if (col_rd == MARK_DONE)
            begin
                res_status_reg <= ST_FOUND;
            end
        end
        if (ctl.back_step)
        begin
            bk_reg <= bk_prev;
        end
        if (ctl.back_store && !(bk_reg == src_c))
        begin
            n_reg <= n_reg + NB'(1);
        end
        if (op_reg == OP_READ && ctl.res_fire)
        begin
            res_status_reg <= ST_DONE;
        end
    end

    // a read answers from the stored path length
    logic [1:0] status_out;
    always_comb
    begin
        status_out = res_status_reg;
        if (op_reg == OP_READ)
        begin
            status_out = st.rd_ok ? ST_FOUND : ST_RANGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.res_fire)
        begin
            status <= status_out;
            path_count <= (32'(len_reg) > 255) ? 8'd255 : 8'(len_reg);
            path_row <= '0;
            path_col <= '0;
            if (op_reg == OP_READ && st.rd_ok)
            begin
                path_row <= 4'(p_cell.r);
                path_col <= 4'(p_cell.c);
            end
        end
    end

    assign result_valid = res_valid_reg;
endmodule

// ===== sv/grid_bfs_shortest_path.sv =====
// ------------------------------------------------------------------
// grid_bfs_shortest_path
// breadth-first grid path searcher with wall map and path store
// ------------------------------------------------------------------
// one word is taken when start is high and busy low; its result shows
// on the outputs for one cycle with done high and cannot be stalled.
// a wall write passes through the check and result states, and a path
// read also waits on the path memory read; a search first clears
// every mark, then runs the breadth-first walk and the path trace,
// paced by the single read port of each map memory. busy drops in
// the cycle done is high, so the next word can be taken there
module grid_bfs_shortest_path #(
    parameter int MAX_ROWS_P = gbfs_pkg::MAX_ROWS_C,
    parameter int MAX_COLS_P = gbfs_pkg::MAX_COLS_C
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [3:0] cell_row,
    input  logic [3:0] cell_col,
    input  logic       wall_bit,
    input  logic [3:0] dest_row,
    input  logic [3:0] dest_col,
    input  logic [7:0] path_index,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    output logic       done,
    output logic [1:0] status,
    output logic [7:0] path_count,
    output logic [3:0] path_row,
    output logic [3:0] path_col
);
    import gbfs_pkg::*;

    ctrl_t ctl;
    stat_t st;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    gbfs_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .st, .ctl);

    gbfs_datapath #(.MAX_ROWS_P(MAX_ROWS_P), .MAX_COLS_P(MAX_COLS_P)) u_dp (
        .clk, .rst_n, .ctl, .st,
        .cfg_we(cfg_valid), .cfg_sel(cfg_index), .cfg_val(cfg_data),
        .op, .cell_row, .cell_col, .wall_bit, .dest_row, .dest_col, .path_index,
        .result_valid(done), .status, .path_count, .path_row, .path_col);
endmodule

// ===== sv/gbfs_checker.sv =====
// ------------------------------------------------------------------
// gbfs_checker
// port level checks of the grid path searcher
// ------------------------------------------------------------------
module gbfs_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic [1:0] status
);
    `include "grid_bfs_shortest_path_assert.svh"

    `GBFS_ASSERT_NXT(a_start_busy, start && !busy, busy)
    `GBFS_ASSERT_NXT(a_done_single, done, !done)
    `GBFS_ASSERT_IMP(a_done_idle, done, !busy)
    `GBFS_ASSERT_NXT(a_busy_until_done, busy && !done, busy || done)
    `GBFS_ASSERT_IMP(a_status_known, done, !$isunknown(status))
endmodule

bind grid_bfs_shortest_path gbfs_checker u_checker (.clk, .rst_n, .start, .busy,
    .done, .status);

// ===== bench/testbench.sv =====
// ------------------------------------------------------------------
// testbench
// self-checking bench for the grid breadth-first path searcher
// ------------------------------------------------------------------
// the whole wall map is written free first. directed words then hit
// the corner cases: longest path, source on a wall, walled-in source,
// source equal to destination, reads past the path end, grid sizes of
// zero, one and above the array, and the unused opcode. random phases
// follow under several grid sizes. each phase is mostly wall churn,
// searches inside the grid and reads of the stored path. a predictor
// computes every result at the moment its word is accepted.
// ------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gbfs_pkg::*;

    localparam int NCELLS = MAX_ROWS_C * MAX_COLS_C;

    typedef struct {
        logic [1:0] op;
        logic [3:0] cell_row;
        logic [3:0] cell_col;
        logic       wall_bit;
        logic [3:0] dest_row;
        logic [3:0] dest_col;
        logic [7:0] path_index;
    } word_t;

    typedef struct {
        logic [1:0] status;
        logic [7:0] path_count;
        logic [3:0] path_row;
        logic [3:0] path_col;
    } answer_t;

    logic clk, rst_n, start, busy, done;
    logic [1:0] op;
    logic [3:0] cell_row, cell_col, dest_row, dest_col;
    logic       wall_bit;
    logic [7:0] path_index;
    logic       cfg_valid, cfg_ready, cfg_index;
    logic [4:0] cfg_data;
    logic [1:0] status;
    logic [7:0] path_count;
    logic [3:0] path_row, path_col;

    grid_bfs_shortest_path DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .cell_row(cell_row), .cell_col(cell_col),
        .wall_bit(wall_bit), .dest_row(dest_row), .dest_col(dest_col),
        .path_index(path_index), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .status(status), .path_count(path_count),
        .path_row(path_row), .path_col(path_col)
    );

    // words waiting to be driven, and answers waiting to come back
    word_t   pending_words[$];
    answer_t awaited_answers[$];
    int      error_count = 0;
    int      words_taken = 0;
    int      paths_found = 0;
    bit      word_taken = 0;
    int      gap_left = 0;

    // predictor state
    logic [4:0] grid_rows_m = 5'd16;
    logic [4:0] grid_cols_m = 5'd16;
    bit   wall_m[NCELLS];
    logic [1:0] color_m[NCELLS];
    logic [1:0] parent_m[NCELLS];
    int   visit_m[NCELLS];
    int   route_m[NCELLS];
    int   route_len = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // effective grid size after clamping the register
    function automatic int clamp_size(input logic [4:0] v, input int lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    // cell this one was reached from, by undoing its move
    function automatic int came_from(input int idx);
        int r, c;
        r = idx / MAX_COLS_C;
        c = idx % MAX_COLS_C;
        case (parent_m[idx])
            2'd0: r = r - 1;
            2'd1: r = r + 1;
            2'd2: c = c + 1;
            default: c = c - 1;
        endcase
        return ((r * MAX_COLS_C + c) % NCELLS + NCELLS) % NCELLS;
    endfunction

    function automatic logic [1:0] search_grid(input int sr, sc, dr, dc);
        int rows, cols, head, tail, u, r, c, nr, nc, v, src, dst, n, cur;
        bit ok;
        rows = clamp_size(grid_rows_m, MAX_ROWS_C);
        cols = clamp_size(grid_cols_m, MAX_COLS_C);
        head = 0;
        tail = 0;
        foreach (color_m[i]) color_m[i] = MARK_UNSEEN;
        if (sr >= rows || sc >= cols || dr >= rows || dc >= cols) return ST_UNREACH;
        src = sr * MAX_COLS_C + sc;
        dst = dr * MAX_COLS_C + dc;
        if (wall_m[src]) return ST_UNREACH;
        color_m[src] = MARK_QUEUED;
        visit_m[tail++] = src;
        while (head != tail && head < NCELLS)
        begin
            u = visit_m[head++];
            r = u / MAX_COLS_C;
            c = u % MAX_COLS_C;
            for (int d = 0; d < 4; d++)
            begin
                nr = r;
                nc = c;
                // neighbour order: row+1, row-1, col-1, col+1
                case (d)
                    0: begin ok = (r + 1 < rows); nr = r + 1; end
                    1: begin ok = (r > 0); nr = r - 1; end
                    2: begin ok = (c > 0); nc = c - 1; end
                    default: begin ok = (c + 1 < cols); nc = c + 1; end
                endcase
                if (ok)
                begin
                    v = nr * MAX_COLS_C + nc;
                    if (!wall_m[v] && color_m[v] == MARK_UNSEEN && tail < NCELLS)
                    begin
                        color_m[v] = MARK_QUEUED;
                        parent_m[v] = d[1:0];
                        visit_m[tail++] = v;
                    end
                end
            end
            color_m[u] = MARK_DONE;
        end
        if (color_m[dst] != MARK_DONE) return ST_UNREACH;
        if (dst == src)
        begin
            route_len = 0;
            return ST_FOUND;
        end
        // walk back once to count, once more to store from the source side
        n = 0;
        cur = came_from(dst);
        while (cur != src && n < NCELLS)
        begin
            n++;
            cur = came_from(cur);
        end
        cur = came_from(dst);
        for (int k = 0; k < n; k++)
        begin
            route_m[n - 1 - k] = cur;
            cur = came_from(cur);
        end
        route_len = n;
        return ST_FOUND;
    endfunction

    function automatic answer_t predict_word(input word_t w);
        answer_t a;
        int entry;
        a.status = ST_DONE;
        a.path_row = '0;
        a.path_col = '0;
        if (w.op == OP_WRITE)
            wall_m[w.cell_row * MAX_COLS_C + w.cell_col] = w.wall_bit;
        else if (w.op == OP_SEARCH)
        begin
            a.status = search_grid(w.cell_row, w.cell_col, w.dest_row, w.dest_col);
            if (a.status == ST_FOUND) paths_found++;
        end
        else if (w.op == OP_READ)
        begin
            if (w.path_index < route_len)
            begin
                entry = route_m[w.path_index];
                a.status = ST_FOUND;
                a.path_row = 4'(entry / MAX_COLS_C);
                a.path_col = 4'(entry % MAX_COLS_C);
            end
            else
                a.status = ST_RANGE;
        end
        // unused opcode falls through as a plain done
        a.path_count = (route_len > 255) ? 8'd255 : route_len[7:0];
        return a;
    endfunction

    // driver: words change on the falling edge, random gap between words
    always @(negedge clk)
    begin
        word_t w;
        if (rst_n)
        begin
            if (!start || word_taken)
            begin
                word_taken = 0;
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words.pop_front();
                    op <= w.op;
                    cell_row <= w.cell_row;
                    cell_col <= w.cell_col;
                    wall_bit <= w.wall_bit;
                    dest_row <= w.dest_row;
                    dest_col <= w.dest_col;
                    path_index <= w.path_index;
                    start <= 1'b1;
                    // at least half the words follow back to back
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 16);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // acceptance and result checking on the rising edge
    always @(posedge clk)
    begin
        word_t w;
        answer_t exp_a;
        if (rst_n && start && !busy)
        begin
            w.op = op;
            w.cell_row = cell_row;
            w.cell_col = cell_col;
            w.wall_bit = wall_bit;
            w.dest_row = dest_row;
            w.dest_col = dest_col;
            w.path_index = path_index;
            awaited_answers.push_back(predict_word(w));
            words_taken++;
            word_taken = 1;
        end
        if (rst_n && done)
        begin
            if (awaited_answers.size() == 0)
            begin
                $display("%t: result with no word pending, status %0d", $time, status);
                error_count++;
            end
            else
            begin
                exp_a = awaited_answers.pop_front();
                if (status !== exp_a.status)
                begin
                    $display("%t: status expected %0d actual %0d", $time, exp_a.status, status);
                    error_count++;
                end
                if (path_count !== exp_a.path_count)
                begin
                    $display("%t: path_count expected %0d actual %0d",
                             $time, exp_a.path_count, path_count);
                    error_count++;
                end
                if (path_row !== exp_a.path_row)
                begin
                    $display("%t: path_row expected %0d actual %0d",
                             $time, exp_a.path_row, path_row);
                    error_count++;
                end
                if (path_col !== exp_a.path_col)
                begin
                    $display("%t: path_col expected %0d actual %0d",
                             $time, exp_a.path_col, path_col);
                    error_count++;
                end
            end
        end
    end

    task automatic add_word(input logic [1:0] o, input int r, c, input int wb,
                            input int dr, dc, pi);
        word_t w;
        w.op = o;
        w.cell_row = 4'(r);
        w.cell_col = 4'(c);
        w.wall_bit = wb[0];
        w.dest_row = 4'(dr);
        w.dest_col = 4'(dc);
        w.path_index = 8'(pi);
        pending_words.push_back(w);
    endtask

    // register write on its own channel, only while idle
    task automatic write_reg(input logic [0:0] idx, input logic [4:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_ROWS) grid_rows_m = val;
        else grid_cols_m = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let every queued word finish, then allow the tail latency
    task automatic drain();
        while (pending_words.size() > 0 || start || awaited_answers.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [4:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'($urandom_range(17, 31));
            2: return 5'd16;
            default: return 5'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic random_phase(input int count);
        int rows, cols, sel;
        rows = clamp_size(grid_rows_m, MAX_ROWS_C);
        cols = clamp_size(grid_cols_m, MAX_COLS_C);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                // walls stay sparse so that most searches get through
                add_word(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
                         ($urandom_range(0, 3) == 0), $urandom, $urandom, $urandom);
            else if (sel < 60)
                add_word(OP_SEARCH, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                         $urandom, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                         $urandom);
            else if (sel < 65)
                add_word(OP_SEARCH, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            else if (sel < 90)
                add_word(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, rows * cols));
            else if (sel < 97)
                add_word(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 255));
            else
                add_word(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_WRITE;
        cell_row = '0;
        cell_col = '0;
        wall_bit = 1'b0;
        dest_row = '0;
        dest_col = '0;
        path_index = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every map cell gets a defined value before any search
        for (int r = 0; r < MAX_ROWS_C; r++)
            for (int c = 0; c < MAX_COLS_C; c++)
                add_word(OP_WRITE, r, c, 1'b0, 0, 0, 0);
        // read before any path exists
        add_word(OP_READ, 0, 0, 0, 0, 0, 0);
        // corner to corner on the full grid, then reads at the edges
        add_word(OP_SEARCH, 0, 0, 0, 15, 15, 0);
        add_word(OP_READ, 0, 0, 0, 0, 0, 0);
        add_word(OP_READ, 0, 0, 0, 0, 0, 28);
        add_word(OP_READ, 0, 0, 0, 0, 0, 29);
        add_word(OP_READ, 15, 15, 1, 15, 15, 255);
        add_word(OP_SEARCH, 15, 15, 1, 0, 0, 0);
        // source on a wall
        add_word(OP_WRITE, 5, 5, 1, 0, 0, 0);
        add_word(OP_SEARCH, 5, 5, 0, 9, 9, 0);
        // walled-in source keeps the previous path
        add_word(OP_WRITE, 0, 1, 1, 0, 0, 0);
        add_word(OP_WRITE, 1, 0, 1, 0, 0, 0);
        add_word(OP_SEARCH, 0, 0, 0, 3, 3, 0);
        add_word(OP_READ, 0, 0, 0, 0, 0, 5);
        // source equal to destination
        add_word(OP_SEARCH, 7, 7, 0, 7, 7, 0);
        add_word(OP_READ, 0, 0, 0, 0, 0, 0);
        add_word(2'd3, 15, 15, 1, 15, 15, 255);
        add_word(OP_WRITE, 0, 1, 0, 0, 0, 0);
        add_word(OP_WRITE, 1, 0, 0, 0, 0, 0);
        drain();

        // one by one grid: only the single cell is reachable
        write_reg(CFG_ROWS, 5'd1);
        write_reg(CFG_COLS, 5'd1);
        add_word(OP_SEARCH, 0, 0, 0, 0, 0, 0);
        add_word(OP_SEARCH, 0, 0, 0, 0, 1, 0);
        add_word(OP_SEARCH, 1, 0, 0, 0, 0, 0);
        drain();

        // zero acts as one, oversize acts as the full width
        write_reg(CFG_ROWS, 5'd0);
        write_reg(CFG_COLS, 5'd31);
        add_word(OP_SEARCH, 0, 0, 0, 0, 15, 0);
        add_word(OP_READ, 0, 0, 0, 0, 0, 13);
        add_word(OP_SEARCH, 0, 15, 0, 1, 0, 0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_ROWS, pick_size());
            write_reg(CFG_COLS, pick_size());
            random_phase(120);
            drain();
        end

        $display("covered %0d words across 9 grid settings, %0d searches found a path",
                 words_taken, paths_found);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("timeout with %0d results outstanding", awaited_answers.size());
        $display("Test completed with failures");
        $finish;
    end
endmodule
